[rtl/itar_pkg.sv]
// itar_pkg: shared types, constants and the digit-to-character function
// for the integer to ascii radix converter; no dependencies
package itar_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 32;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_TEN   = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;
  localparam logic [CHAR_W-1:0]  DIGIT_TEN   = 8'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  typedef struct packed {
    logic load;
    logic div_go;
    logic store;
    logic rd_issue;
    logic emit_sign;
    logic emit_digit;
  } itar_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mag_zero;
    logic count_full;
    logic neg;
    logic count_zero;
  } itar_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d > DIGIT_NINE) begin
      return CHAR_A + dw - DIGIT_TEN;
    end
    return CHAR_ZERO + dw;
  endfunction

endpackage

[rtl/integer_to_ascii_radix.sv]
// integer_to_ascii_radix: top level, converts an integer to ascii text
// depends on itar_pkg, itar_ctrl, itar_datapath
//
// channel   direction  handshake               payload
// input     in         start & !busy           number
// result    out        strobe (no back-press)  character, last
// config    in         cfg_valid & cfg_ready   cfg_data (radix)
//
// each digit comes from one division in the bit-serial divider
// emission reads each digit back from the buffer and then sends it, after a leading minus
// busy stays high from accept until the beat with last has gone out
// synchronous reset returns the sequencer to idle and radix to ten
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = itar_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] number,
  output logic                          strobe,
  output logic [itar_pkg::CHAR_W-1:0]   character,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itar_pkg::RADIX_W-1:0]  cfg_data
);

  itar_pkg::itar_cmd_t cmd;
  itar_pkg::itar_sts_t sts;

  assign cfg_ready = 1'b1;

  itar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .strobe(strobe)
  );

  itar_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .number   (number),
    .cmd      (cmd),
    .sts      (sts),
    .character(character),
    .last     (last)
  );

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy)
    else $error("busy after final beat");

  a_first_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !strobe)
    else $error("result beat in the accept cycle");
`endif

endmodule

[rtl/itar_ram.sv]
// itar_ram: generic single write port ram with registered read
// no dependencies
module itar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/itar_div.sv]
// itar_div: restoring divider, one quotient bit per cycle, small divisor
// depends on itar_pkg
module itar_div #(
  parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [VALUE_WIDTH-1:0]       dividend,
  input  logic [itar_pkg::RADIX_W-1:0] divisor,
  output logic                         done,
  output logic [VALUE_WIDTH-1:0]       quotient,
  output logic [itar_pkg::RADIX_W-1:0] remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                         running;
  logic [CNT_W-1:0]             cnt;
  logic [VALUE_WIDTH-1:0]       quo;
  logic [itar_pkg::RADIX_W-1:0] rem;
  logic [itar_pkg::RADIX_W:0]   trial;
  logic                         fits;
  logic [itar_pkg::RADIX_W:0]   rem_next;

  always_comb begin
    trial    = {rem, quo[VALUE_WIDTH-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? (trial - {1'b0, divisor}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(VALUE_WIDTH);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[VALUE_WIDTH-2:0], fits};
      rem <= rem_next[itar_pkg::RADIX_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[rtl/itar_datapath.sv]
// itar_datapath: radix register, magnitude, digit buffer and output mux
// depends on itar_pkg, itar_div, itar_ram
module itar_datapath #(
  parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = itar_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [itar_pkg::RADIX_W-1:0]  cfg_data,
  input  logic signed [VALUE_WIDTH-1:0] number,
  input  itar_pkg::itar_cmd_t           cmd,
  output itar_pkg::itar_sts_t           sts,
  output logic [itar_pkg::CHAR_W-1:0]   character,
  output logic                          last
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  logic [itar_pkg::RADIX_W-1:0] radix;
  logic [itar_pkg::RADIX_W-1:0] base;
  logic [itar_pkg::RADIX_W-1:0] base_next;
  logic                         neg;
  logic                         neg_next;
  logic [VALUE_WIDTH-1:0]       mag;
  logic [VALUE_WIDTH-1:0]       num_u;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_m1;
  logic [CW-1:0]                limit;
  logic                         div_done;
  logic [VALUE_WIDTH-1:0]       quotient;
  logic [itar_pkg::RADIX_W-1:0] remainder;
  logic [itar_pkg::CHAR_W-1:0]  rdata;

  always_comb begin
    priority if (radix < itar_pkg::RADIX_MIN) begin
      base_next = itar_pkg::RADIX_MIN;
    end else if (radix > itar_pkg::RADIX_MAX) begin
      base_next = itar_pkg::RADIX_MAX;
    end else begin
      base_next = radix;
    end
    num_u    = $unsigned(number);
    neg_next = (base_next == itar_pkg::RADIX_TEN) && num_u[VALUE_WIDTH-1];
    count_m1 = count - 1'b1;
    limit    = neg ? CW'(MAX_DIGITS - 1) : CW'(MAX_DIGITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itar_pkg::RADIX_RESET;
    end else if (cfg_valid) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neg   <= 1'b0;
      mag   <= '0;
      count <= '0;
    end else if (cmd.load) begin
      base  <= base_next;
      neg   <= neg_next;
      mag   <= neg_next ? (~num_u + 1'b1) : num_u;
      count <= '0;
    end else if (cmd.store) begin
      mag   <= quotient;
      count <= count + 1'b1;
    end else if (cmd.rd_issue) begin
      count <= count_m1;
    end
  end

  itar_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (mag),
    .divisor  (base),
    .done     (div_done),
    .quotient (quotient),
    .remainder(remainder)
  );

  itar_ram #(
    .WIDTH(itar_pkg::CHAR_W),
    .DEPTH(MAX_DIGITS)
  ) u_buf (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(count[AW-1:0]),
    .wdata(itar_pkg::digit_char(remainder)),
    .raddr(count_m1[AW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    sts.div_done   = div_done;
    sts.mag_zero   = mag == '0;
    sts.count_full = count == limit;
    sts.neg        = neg;
    sts.count_zero = count == '0;
    character      = cmd.emit_sign ? itar_pkg::CHAR_MINUS : rdata;
    last           = cmd.emit_digit && (count == '0);
  end

endmodule

[rtl/itar_ctrl.sv]
// itar_ctrl: sequencer for load, repeated division, sign and digit emission
// depends on itar_pkg
module itar_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  itar_pkg::itar_sts_t sts,
  output itar_pkg::itar_cmd_t cmd,
  output logic                busy,
  output logic                strobe
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.div_go = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.store  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mag_zero || sts.count_full) begin
          state_next = sts.neg ? S_SIGN : S_READ;
        end else begin
          state_next = S_START;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        state_next     = sts.count_zero ? S_IDLE : S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy   = state != S_IDLE;
  assign strobe = cmd.emit_sign || cmd.emit_digit;

endmodule

[bench/tb_integer_to_ascii_radix.sv]
// tb_integer_to_ascii_radix: self-checking bench for the integer to ascii radix converter
// directed and random numbers over many radix settings, each checked character by character
// depends on itar_pkg and integer_to_ascii_radix
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix;

  typedef struct packed {
    logic [itar_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } char_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [31:0]            number = '0;
  logic                          strobe;
  logic [itar_pkg::CHAR_W-1:0]   character;
  logic                          last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [itar_pkg::RADIX_W-1:0]  cfg_data = '0;

  logic [31:0]                   number_queue[$];
  char_beat_t                    pending_chars[$];
  logic [itar_pkg::RADIX_W-1:0]  radix_setting = itar_pkg::RADIX_RESET;
  logic                          accept_seen = 1'b0;
  int                            gap_left = 0;
  int                            burst_left = 0;
  int                            errors = 0;

  integer_to_ascii_radix dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .number    (number),
    .strobe    (strobe),
    .character (character),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected text of one number under the current radix
  function automatic void spell_number(input logic [31:0] value);
    logic [itar_pkg::RADIX_W-1:0] base;
    logic [31:0]                  mag;
    logic [31:0]                  d;
    logic [itar_pkg::CHAR_W-1:0]  digits[32];
    int                           n;
    int                           limit;
    logic                         neg;
    char_beat_t                   beat;
    base = radix_setting;
    if (base < itar_pkg::RADIX_MIN) base = itar_pkg::RADIX_MIN;
    else if (base > itar_pkg::RADIX_MAX) base = itar_pkg::RADIX_MAX;
    neg = (base == itar_pkg::RADIX_TEN) && value[31];
    mag = neg ? (32'd0 - value) : value;
    limit = neg ? 31 : 32;
    n = 0;
    if (mag == 0) begin
      digits[0] = itar_pkg::CHAR_ZERO;
      n = 1;
    end else begin
      while (mag != 0 && n < limit) begin
        d = mag % 32'(base);
        digits[n] = (d > 9) ? itar_pkg::CHAR_A + itar_pkg::CHAR_W'(d) - 8'd10
                            : itar_pkg::CHAR_ZERO + itar_pkg::CHAR_W'(d);
        mag = mag / 32'(base);
        n++;
      end
    end
    if (neg) begin
      beat.ch = itar_pkg::CHAR_MINUS;
      beat.last = 1'b0;
      pending_chars.push_back(beat);
    end
    while (n > 0) begin
      n--;
      beat.ch = digits[n];
      beat.last = (n == 0);
      pending_chars.push_back(beat);
    end
  endfunction

  // input beat accepted at the rising edge
  always @(posedge clk) begin
    accept_seen = !rst && start && !busy;
    if (accept_seen) spell_number(number);
  end

  // driver: bursts of numbers with random gaps, changes on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || accept_seen) begin
      if (gap_left == 0 && number_queue.size() != 0) begin
        start <= 1'b1;
        number <= number_queue.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 5);
            default: gap_left = $urandom_range(1, 400);
          endcase
        end
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // monitor: every character beat against the oldest expectation
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got char %h last %b",
                 $time, character, last);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (character !== want.ch) begin
          $display("%0t: character mismatch, expected %h, got %h", $time, want.ch, character);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last mismatch, expected %b, got %b", $time, want.last, last);
          errors++;
        end
      end
    end
  end

  task automatic write_radix(input logic [itar_pkg::RADIX_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    radix_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (number_queue.size() != 0 || start || pending_chars.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int random_items;
    int count;
    logic [itar_pkg::RADIX_W-1:0] r;
    logic [31:0] value;
    random_items = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_radix(itar_pkg::RADIX_TEN);
    number_queue = '{32'd0, 32'd1, 32'hffffffff, 32'd9, 32'd10, 32'hfffffff6,
                     32'h7fffffff, 32'h80000000, 32'd1000000000};
    drain();
    write_radix(6'd16);
    number_queue = '{32'd0, 32'hffffffff, 32'habcdef09, 32'h80000000};
    drain();
    write_radix(itar_pkg::RADIX_MIN);
    number_queue = '{32'hffffffff, 32'd1, 32'h80000000};
    drain();
    write_radix(itar_pkg::RADIX_MAX);
    number_queue = '{32'd35, 32'd36, 32'hffffffff, 32'h7fffffff};
    drain();
    // out-of-range radix settings clamp to two or thirty-six
    write_radix(6'd0);
    number_queue = '{32'd5};
    drain();
    write_radix(6'd1);
    number_queue = '{32'hffffffff};
    drain();
    write_radix(6'd37);
    number_queue = '{32'd35};
    drain();
    write_radix(6'd63);
    number_queue = '{32'd36};
    drain();
    write_radix(6'd8);
    number_queue = '{32'h80000000};
    drain();

    while (random_items < 100) begin
      case ($urandom_range(0, 4))
        0: r = itar_pkg::RADIX_TEN;
        1: r = itar_pkg::RADIX_W'($urandom_range(0, 63));
        2: begin
          case ($urandom_range(0, 2))
            0: r = itar_pkg::RADIX_MIN;
            1: r = 6'd16;
            default: r = itar_pkg::RADIX_MAX;
          endcase
        end
        default: r = itar_pkg::RADIX_W'($urandom_range(2, 36));
      endcase
      write_radix(r);
      count = $urandom_range(4, 16);
      repeat (count) begin
        case ($urandom_range(0, 5))
          0: value = $urandom_range(0, 100);
          1: value = 32'd0 - $urandom_range(1, 1000);
          2: begin
            case ($urandom_range(0, 3))
              0: value = 32'h80000000;
              1: value = 32'h7fffffff;
              2: value = 32'hffffffff;
              default: value = 32'd0;
            endcase
          end
          3: value = $urandom >> $urandom_range(0, 31);
          default: value = $urandom;
        endcase
        number_queue.push_back(value);
      end
      random_items += count;
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** integer_to_ascii_radix: PASSED **");
    end else begin
      $display("** integer_to_ascii_radix: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d characters outstanding", pending_chars.size());
    $display("** integer_to_ascii_radix: FAILED **");
    $finish;
  end

endmodule
